// File: design/assert_macros.svh
// Assertion macros for the design files; only lobm_table uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LOBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define LOBM_ASSERT(lbl, clk, rst_n, prop)
`define LOBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/lobm_pkg.sv
package lobm_pkg;

    localparam int LEVELS    = 64;
    localparam int CNT_W     = $clog2(LEVELS + 1);
    localparam int PRICE_W   = 32;
    localparam int AMT_W     = 32;
    localparam int QTY_W     = 48;
    localparam int MOD_W     = 30;
    localparam int MOD_STEPS = 3;
    localparam int STEP_W    = $clog2(MOD_STEPS + 1);

    // The quotient estimate uses the total's bits from HI_LSB upward.
    localparam int HI_LSB      = 29;
    localparam int HI_W        = QTY_W - HI_LSB;
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 30;
    localparam int RES_W       = 32;

    localparam logic [MOD_W-1:0]   MOD_VAL   = 30'd1000000007;
    // Largest integer not above 2^59 / MOD_VAL.
    localparam logic [RECIP_W-1:0] MOD_RECIP = 30'd576460748;
    localparam logic [QTY_W-1:0]   QTY_MAX   = {QTY_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic match;
        logic find;
        logic place;
        logic mod_start;
        logic mod_step;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_zero;
        logic match_go;
        logic rem_zero;
        logic mod_done;
        logic out_free;
    } ctrl_status_t;

    // Operations on one level table.
    typedef struct packed {
        logic pop;
        logic dec;
        logic find;
        logic place;
    } tbl_cmd_t;

endpackage

// File: design/lobm_table.sv
`include "assert_macros.svh"

module lobm_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          descending,
    input  lobm_pkg::tbl_cmd_t            cmd,
    input  logic [lobm_pkg::PRICE_W-1:0]  key_price,
    input  logic [lobm_pkg::QTY_W-1:0]    dec_amount,
    input  logic [lobm_pkg::QTY_W-1:0]    add_amount,
    output logic [lobm_pkg::QTY_W-1:0]    head_qty,
    output logic                          head_cross,
    output logic [lobm_pkg::QTY_W-1:0]    add_placed,
    output logic                          drop
);

    logic [lobm_pkg::PRICE_W-1:0] price_reg [lobm_pkg::LEVELS];
    logic [lobm_pkg::QTY_W-1:0]   qty_reg   [lobm_pkg::LEVELS];
    logic [lobm_pkg::CNT_W-1:0]   count_reg;
    logic [lobm_pkg::LEVELS-1:0]  before_reg;
    logic [lobm_pkg::LEVELS-1:0]  eq_reg;
    logic                         hit_reg;
    logic [lobm_pkg::QTY_W-1:0]   hitqty_reg;

    logic [lobm_pkg::LEVELS-1:0]  before_w;
    logic [lobm_pkg::LEVELS-1:0]  eq_w;
    logic [lobm_pkg::QTY_W-1:0]   hitqty_w;
    logic [lobm_pkg::QTY_W-1:0]   room;
    logic                         full;

    // Per-level compares against the key price; valid levels sit below the count.
    always_comb
    begin
        hitqty_w = '0;
        for (int i = 0; i < lobm_pkg::LEVELS; i++)
        begin
            before_w[i] = (lobm_pkg::CNT_W'(i) < count_reg) &&
                          (descending ? (price_reg[i] > key_price)
                                      : (price_reg[i] < key_price));
            eq_w[i]     = (lobm_pkg::CNT_W'(i) < count_reg) &&
                          (price_reg[i] == key_price);
            if (eq_w[i])
            begin
                hitqty_w = hitqty_w | qty_reg[i];
            end
        end
    end

    assign head_qty   = qty_reg[0];
    assign head_cross = (count_reg != '0) &&
                        (descending ? (price_reg[0] >= key_price)
                                    : (price_reg[0] <= key_price));
    assign full       = (count_reg == lobm_pkg::CNT_W'(lobm_pkg::LEVELS));
    assign room       = lobm_pkg::QTY_MAX - hitqty_reg;
    assign add_placed = (hit_reg && (room < add_amount)) ? room : add_amount;
    assign drop       = !hit_reg && full;

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            for (int i = 0; i < lobm_pkg::LEVELS - 1; i++)
            begin
                price_reg[i] <= price_reg[i+1];
                qty_reg[i]   <= qty_reg[i+1];
            end
        end
        else if (cmd.dec)
        begin
            qty_reg[0] <= qty_reg[0] - dec_amount;
        end
        else if (cmd.place)
        begin
            if (hit_reg)
            begin
                for (int i = 0; i < lobm_pkg::LEVELS; i++)
                begin
                    if (eq_reg[i])
                    begin
                        qty_reg[i] <= qty_reg[i] + add_placed;
                    end
                end
            end
            else if (!full)
            begin
                if (!before_reg[0])
                begin
                    price_reg[0] <= key_price;
                    qty_reg[0]   <= add_amount;
                end
                for (int i = 1; i < lobm_pkg::LEVELS; i++)
                begin
                    if (!before_reg[i])
                    begin
                        if (before_reg[i-1])
                        begin
                            price_reg[i] <= key_price;
                            qty_reg[i]   <= add_amount;
                        end
                        else
                        begin
                            price_reg[i] <= price_reg[i-1];
                            qty_reg[i]   <= qty_reg[i-1];
                        end
                    end
                end
            end
        end

        if (cmd.find)
        begin
            before_reg <= before_w;
            eq_reg     <= eq_w;
            hit_reg    <= |eq_w;
            hitqty_reg <= hitqty_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.pop)
        begin
            count_reg <= count_reg - 1'b1;
        end
        else if (cmd.place && !hit_reg && !full)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    `LOBM_ASSERT(a_count_range, clk, rst_n, count_reg <= lobm_pkg::CNT_W'(lobm_pkg::LEVELS))
    `LOBM_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, cmd.pop, count_reg != '0)
    `LOBM_ASSERT_IMPL(a_place_grows, clk, rst_n, cmd.place && !hit_reg && !full, ##1 (count_reg == $past(count_reg) + 1'b1))

endmodule

// File: design/lobm_mod.sv
module lobm_mod
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        step,
    input  logic [lobm_pkg::QTY_W-1:0]  value,
    output logic [lobm_pkg::MOD_W-1:0]  result,
    output logic                        done
);

    logic [lobm_pkg::QTY_W-1:0]                   v_reg;
    logic [lobm_pkg::HI_W-1:0]                    q_reg;
    logic [lobm_pkg::RES_W-1:0]                   r_reg;
    logic [lobm_pkg::MOD_W-1:0]                   m_reg;
    logic [lobm_pkg::STEP_W-1:0]                  cnt_reg;
    logic [lobm_pkg::HI_W+lobm_pkg::RECIP_W-1:0]  q_prod;
    logic [lobm_pkg::HI_W+lobm_pkg::MOD_W-1:0]    qm_prod;
    logic [lobm_pkg::RES_W-1:0]                   r_sub;
    logic [lobm_pkg::HI_W-1:0]                    q_next;
    logic [lobm_pkg::RES_W-1:0]                   r_next;
    logic [lobm_pkg::MOD_W-1:0]                   m_next;

    // The quotient is estimated from the top bits of the total with a
    // reciprocal multiply; the estimate is low by at most one, so the
    // remainder left after the back-multiply needs one conditional subtract.
    assign q_prod  = {{lobm_pkg::RECIP_W{1'b0}}, v_reg[lobm_pkg::QTY_W-1:lobm_pkg::HI_LSB]} *
                     {{lobm_pkg::HI_W{1'b0}}, lobm_pkg::MOD_RECIP};
    assign q_next  = q_prod[lobm_pkg::HI_W+lobm_pkg::RECIP_W-1:lobm_pkg::RECIP_SHIFT];
    assign qm_prod = {{lobm_pkg::MOD_W{1'b0}}, q_reg} *
                     {{lobm_pkg::HI_W{1'b0}}, lobm_pkg::MOD_VAL};
    assign r_next  = v_reg[lobm_pkg::RES_W-1:0] - qm_prod[lobm_pkg::RES_W-1:0];
    assign r_sub   = r_reg - {{(lobm_pkg::RES_W - lobm_pkg::MOD_W){1'b0}}, lobm_pkg::MOD_VAL};
    assign m_next  = (r_reg >= {{(lobm_pkg::RES_W - lobm_pkg::MOD_W){1'b0}}, lobm_pkg::MOD_VAL})
                     ? r_sub[lobm_pkg::MOD_W-1:0] : r_reg[lobm_pkg::MOD_W-1:0];

    assign result = m_reg;
    assign done   = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
        end
        if (step && (cnt_reg == lobm_pkg::STEP_W'(lobm_pkg::MOD_STEPS)))
        begin
            q_reg <= q_next;
        end
        if (step && (cnt_reg == lobm_pkg::STEP_W'(lobm_pkg::MOD_STEPS - 1)))
        begin
            r_reg <= r_next;
        end
        if (step && (cnt_reg == lobm_pkg::STEP_W'(1)))
        begin
            m_reg <= m_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= lobm_pkg::STEP_W'(lobm_pkg::MOD_STEPS);
        end
        else if (step && !done)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// File: design/lobm_datapath.sv
module lobm_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lobm_pkg::ctrl_cmd_t           cmd,
    output lobm_pkg::ctrl_status_t        st,
    input  logic [lobm_pkg::PRICE_W-1:0]  limit_price,
    input  logic [lobm_pkg::AMT_W-1:0]    order_amount,
    input  logic                          order_side,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [lobm_pkg::AMT_W-1:0]    filled_amount,
    output logic [lobm_pkg::QTY_W-1:0]    backlog_total,
    output logic [lobm_pkg::MOD_W-1:0]    backlog_total_mod,
    output logic                          remainder_dropped
);

    logic [lobm_pkg::PRICE_W-1:0] price_reg;
    logic                         side_reg;
    logic [lobm_pkg::AMT_W-1:0]   rem_reg;
    logic [lobm_pkg::AMT_W-1:0]   filled_reg;
    logic                         drop_reg;
    logic [lobm_pkg::QTY_W-1:0]   total_reg;
    logic                         out_valid_reg;
    logic [lobm_pkg::AMT_W-1:0]   filled_out_reg;
    logic [lobm_pkg::QTY_W-1:0]   total_out_reg;
    logic [lobm_pkg::MOD_W-1:0]   mod_out_reg;
    logic                         drop_out_reg;

    lobm_pkg::tbl_cmd_t           buy_cmd;
    lobm_pkg::tbl_cmd_t           sell_cmd;
    logic [lobm_pkg::QTY_W-1:0]   buy_head;
    logic [lobm_pkg::QTY_W-1:0]   sell_head;
    logic                         buy_cross;
    logic                         sell_cross;
    logic [lobm_pkg::QTY_W-1:0]   buy_placed;
    logic [lobm_pkg::QTY_W-1:0]   sell_placed;
    logic                         buy_drop;
    logic                         sell_drop;

    logic [lobm_pkg::QTY_W-1:0]   opp_head;
    logic                         opp_cross;
    logic [lobm_pkg::QTY_W-1:0]   own_placed;
    logic                         own_drop;
    logic [lobm_pkg::QTY_W-1:0]   rem_wide;
    logic [lobm_pkg::AMT_W-1:0]   take;
    logic [lobm_pkg::QTY_W-1:0]   take_wide;
    logic                         pop_now;
    logic [lobm_pkg::QTY_W:0]     sum;
    logic [lobm_pkg::MOD_W-1:0]   mod_result;
    logic                         mod_done;

    // A buy order works against the sell table and rests on the buy table.
    assign opp_head   = side_reg ? buy_head : sell_head;
    assign opp_cross  = side_reg ? buy_cross : sell_cross;
    assign own_placed = side_reg ? sell_placed : buy_placed;
    assign own_drop   = side_reg ? sell_drop : buy_drop;

    assign rem_wide  = {{(lobm_pkg::QTY_W - lobm_pkg::AMT_W){1'b0}}, rem_reg};
    assign take      = (rem_wide < opp_head) ? rem_reg : opp_head[lobm_pkg::AMT_W-1:0];
    assign take_wide = {{(lobm_pkg::QTY_W - lobm_pkg::AMT_W){1'b0}}, take};

    assign st.in_zero  = (order_amount == '0);
    assign st.match_go = opp_cross && (rem_reg != '0);
    assign st.rem_zero = (rem_reg == '0);
    assign st.mod_done = mod_done;
    assign st.out_free = !out_valid_reg || out_ready;

    assign pop_now = cmd.match && st.match_go && (take_wide == opp_head);

    always_comb
    begin
        buy_cmd.pop    = side_reg && pop_now;
        buy_cmd.dec    = side_reg && cmd.match && st.match_go && !pop_now;
        buy_cmd.find   = !side_reg && cmd.find;
        buy_cmd.place  = !side_reg && cmd.place;
        sell_cmd.pop   = !side_reg && pop_now;
        sell_cmd.dec   = !side_reg && cmd.match && st.match_go && !pop_now;
        sell_cmd.find  = side_reg && cmd.find;
        sell_cmd.place = side_reg && cmd.place;
    end

    lobm_table u_buy
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .descending (1'b1),
        .cmd        (buy_cmd),
        .key_price  (price_reg),
        .dec_amount (take_wide),
        .add_amount (rem_wide),
        .head_qty   (buy_head),
        .head_cross (buy_cross),
        .add_placed (buy_placed),
        .drop       (buy_drop)
    );

    lobm_table u_sell
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .descending (1'b0),
        .cmd        (sell_cmd),
        .key_price  (price_reg),
        .dec_amount (take_wide),
        .add_amount (rem_wide),
        .head_qty   (sell_head),
        .head_cross (sell_cross),
        .add_placed (sell_placed),
        .drop       (sell_drop)
    );

    lobm_mod u_mod
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mod_start),
        .step   (cmd.mod_step),
        .value  (total_reg),
        .result (mod_result),
        .done   (mod_done)
    );

    assign sum = {1'b0, total_reg} + {1'b0, own_placed};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            price_reg  <= limit_price;
            side_reg   <= order_side;
            rem_reg    <= order_amount;
            filled_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (cmd.match && st.match_go)
        begin
            rem_reg    <= rem_reg - take;
            filled_reg <= filled_reg + take;
        end
        else if (cmd.place)
        begin
            drop_reg <= own_drop;
        end

        if (cmd.out_load)
        begin
            filled_out_reg <= filled_reg;
            total_out_reg  <= total_reg;
            mod_out_reg    <= mod_result;
            drop_out_reg   <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.match && st.match_go)
            begin
                total_reg <= (total_reg >= take_wide) ? (total_reg - take_wide) : '0;
            end
            else if (cmd.place && !own_drop)
            begin
                total_reg <= sum[lobm_pkg::QTY_W] ? lobm_pkg::QTY_MAX
                                                  : sum[lobm_pkg::QTY_W-1:0];
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign filled_amount     = filled_out_reg;
    assign backlog_total     = total_out_reg;
    assign backlog_total_mod = mod_out_reg;
    assign remainder_dropped = drop_out_reg;

endmodule

// File: design/lobm_ctrl.sv
module lobm_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lobm_pkg::ctrl_status_t st,
    output lobm_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MATCH  = 7'b0000010,
        S_FIND   = 7'b0000100,
        S_PLACE  = 7'b0001000,
        S_MSTART = 7'b0010000,
        S_MODW   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.in_zero ? S_MSTART : S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match = 1'b1;
                if (!st.match_go)
                begin
                    state_next = st.rem_zero ? S_MSTART : S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MODW;
            end
            S_MODW:
            begin
                cmd.mod_step = 1'b1;
                if (st.mod_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/limit_order_book_matcher.sv
// Limit order book matcher. Each request is one limit order (price, amount,
// side) and produces exactly one result: the amount filled, the total resting
// quantity afterward (saturating at 48 bits), that total modulo 1000000007,
// and a flag set when the unfilled remainder could not rest because its side
// already held the maximum number of price levels. The buy and sell books are
// sorted register tables; matching removes one level from the head per cycle,
// and resting a remainder takes a compare step and then a shift-insert step.
// Orders are processed one at a time: after acceptance an order runs the match
// steps while the opposite head crosses, rests any remainder, and then passes
// the backlog total through the modulo unit, which estimates the quotient with
// a reciprocal multiplication and corrects it with one subtraction. The result
// sits in an output register, so the next order is accepted while a result
// waits to be taken.
module limit_order_book_matcher
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lobm_pkg::PRICE_W-1:0]  limit_price,
    input  logic [lobm_pkg::AMT_W-1:0]    order_amount,
    input  logic                          order_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lobm_pkg::AMT_W-1:0]    filled_amount,
    output logic [lobm_pkg::QTY_W-1:0]    backlog_total,
    output logic [lobm_pkg::MOD_W-1:0]    backlog_total_mod,
    output logic                          remainder_dropped
);

    lobm_pkg::ctrl_cmd_t    cmd;
    lobm_pkg::ctrl_status_t st;

    // The controller sequences each order; the datapath owns both books.
    lobm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    lobm_datapath u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .limit_price       (limit_price),
        .order_amount      (order_amount),
        .order_side        (order_side),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .filled_amount     (filled_amount),
        .backlog_total     (backlog_total),
        .backlog_total_mod (backlog_total_mod),
        .remainder_dropped (remainder_dropped)
    );

endmodule

// File: sim/limit_order_book_matcher_test.sv
`timescale 1ns / 1ps

module limit_order_book_matcher_test;

    localparam longint unsigned BACKLOG_MODULUS = 64'd1000000007;
    localparam int unsigned     CYCLE_LIMIT     = 2000000;
    localparam int              BUY             = 0;
    localparam int              SELL            = 1;

    // One expected result, held until the block returns the matching one.
    typedef struct {
        logic [lobm_pkg::AMT_W-1:0] filled;
        logic [lobm_pkg::QTY_W-1:0] total;
        logic [lobm_pkg::MOD_W-1:0] total_mod;
        logic                       dropped;
    } fill_report_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [lobm_pkg::PRICE_W-1:0]  limit_price;
    logic [lobm_pkg::AMT_W-1:0]    order_amount;
    logic                          order_side;
    logic                          out_valid;
    logic                          out_ready;
    logic [lobm_pkg::AMT_W-1:0]    filled_amount;
    logic [lobm_pkg::QTY_W-1:0]    backlog_total;
    logic [lobm_pkg::MOD_W-1:0]    backlog_total_mod;
    logic                          remainder_dropped;

    // Private copy of the order book. Index 0 holds the buy side, sorted by
    // descending price; index 1 holds the sell side, sorted by ascending price.
    logic [lobm_pkg::PRICE_W-1:0]  book_price [2][lobm_pkg::LEVELS];
    logic [lobm_pkg::QTY_W-1:0]    book_qty   [2][lobm_pkg::LEVELS];
    int                            book_depth [2];
    logic [lobm_pkg::QTY_W-1:0]    resting_qty;

    fill_report_t        pending_fills [$];
    int                  mismatches;
    int unsigned         cycle_count;
    int                  receiver_hold;
    bit                  sender_no_gaps;

    limit_order_book_matcher dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .limit_price       (limit_price),
        .order_amount      (order_amount),
        .order_side        (order_side),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filled_amount     (filled_amount),
        .backlog_total     (backlog_total),
        .backlog_total_mod (backlog_total_mod),
        .remainder_dropped (remainder_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Run the order through the private book and queue the result it must give.
    // The incoming order first eats the opposite side from its best level for as
    // long as the level price crosses the limit; emptied levels leave the head.
    // Whatever remains joins a level at the limit price on its own side, opens a
    // new level there, or is lost when that side already holds every level.
    function automatic void book_order(input logic [lobm_pkg::PRICE_W-1:0] price,
                                       input logic [lobm_pkg::AMT_W-1:0] amount,
                                       input logic side);
        logic [lobm_pkg::QTY_W-1:0] left;
        logic [lobm_pkg::QTY_W-1:0] filled;
        logic [lobm_pkg::QTY_W-1:0] take;
        logic [lobm_pkg::QTY_W-1:0] room;
        logic [lobm_pkg::QTY_W-1:0] add;
        int               own;
        int               opp;
        int               idx;
        int               pos;
        int               k;
        bit               dropped;
        bit               crosses;
        fill_report_t     report;

        left    = {16'd0, amount};
        filled  = '0;
        dropped = 1'b0;
        own     = side ? SELL : BUY;
        opp     = side ? BUY : SELL;

        if (amount != 0)
        begin
            idx = 0;
            while (idx < book_depth[opp] && left != 0)
            begin
                crosses = (opp == BUY) ? (book_price[opp][idx] >= price)
                                       : (book_price[opp][idx] <= price);
                if (!crosses)
                    break;
                take = (left < book_qty[opp][idx]) ? left : book_qty[opp][idx];
                left -= take;
                book_qty[opp][idx] -= take;
                filled += take;
                resting_qty = (resting_qty >= take) ? resting_qty - take : '0;
                if (book_qty[opp][idx] != 0)
                    break;
                idx++;
            end
            if (idx > 0)
            begin
                for (k = 0; k < book_depth[opp] - idx; k++)
                begin
                    book_price[opp][k] = book_price[opp][k + idx];
                    book_qty[opp][k]   = book_qty[opp][k + idx];
                end
                book_depth[opp] -= idx;
            end

            if (left != 0)
            begin
                pos = 0;
                while (pos < book_depth[own] &&
                       ((own == BUY) ? (book_price[own][pos] > price)
                                     : (book_price[own][pos] < price)))
                    pos++;
                if (pos < book_depth[own] && book_price[own][pos] == price)
                begin
                    // Joining a level never drops, but the level may saturate.
                    room = lobm_pkg::QTY_MAX - book_qty[own][pos];
                    add  = (left < room) ? left : room;
                    book_qty[own][pos] += add;
                    resting_qty = (lobm_pkg::QTY_MAX - resting_qty < add)
                                  ? lobm_pkg::QTY_MAX : resting_qty + add;
                end
                else if (book_depth[own] >= lobm_pkg::LEVELS)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    for (k = book_depth[own]; k > pos; k--)
                    begin
                        book_price[own][k] = book_price[own][k - 1];
                        book_qty[own][k]   = book_qty[own][k - 1];
                    end
                    book_price[own][pos] = price;
                    book_qty[own][pos]   = left;
                    book_depth[own]++;
                    resting_qty = (lobm_pkg::QTY_MAX - resting_qty < left)
                                  ? lobm_pkg::QTY_MAX : resting_qty + left;
                end
            end
        end

        report.filled    = filled[lobm_pkg::AMT_W-1:0];
        report.total     = resting_qty;
        report.total_mod = lobm_pkg::MOD_W'({16'd0, resting_qty} % BACKLOG_MODULUS);
        report.dropped   = dropped;
        pending_fills.push_back(report);
    endfunction

    // Offer one request. The sender idles a random number of cycles first,
    // unless a phase has asked for back-to-back traffic. Valid is only lowered
    // when a gap follows, so it never drops and rises within one time step.
    task automatic send_order(input logic [lobm_pkg::PRICE_W-1:0] price,
                              input logic [lobm_pkg::AMT_W-1:0] amount,
                              input logic side);
        int gap;

        gap = sender_no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        limit_price  <= price;
        order_amount <= amount;
        order_side   <= side;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Zero amounts must leave the book untouched at any price and on both sides.
    task automatic test_zero_amount();
        send_order(32'd0, 32'd0, 1'b0);
        send_order(32'hFFFF_FFFF, 32'd0, 1'b1);
        send_order(32'd500, 32'd7, 1'b0);
        send_order(32'd500, 32'd0, 1'b1);
        send_order(32'd500, 32'd0, 1'b0);
    endtask

    // Price and amount extremes, exact fills, partial fills, level joins, and
    // orders that sweep several levels and then rest.
    task automatic test_extremes();
        send_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_order(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_order(32'd0, 32'h0000_0001, 1'b1);
        send_order(32'h8000_0000, 32'h5555_5555, 1'b1);
        send_order(32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0);
        send_order(32'd100, 32'd10, 1'b1);
        send_order(32'd101, 32'd20, 1'b1);
        send_order(32'd102, 32'd30, 1'b1);
        send_order(32'd99, 32'd5, 1'b0);
        send_order(32'd101, 32'd25, 1'b0);
        send_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_order(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_order(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    // Fill the buy side to capacity, then check that a new price is dropped
    // while an existing price still joins. The receiver holds off meanwhile, so
    // the output register fills and the block must stall its input.
    task automatic test_full_side();
        int lvl;

        receiver_hold  = 400;
        sender_no_gaps = 1'b1;
        for (lvl = 0; lvl < lobm_pkg::LEVELS; lvl++)
            send_order(32'd1000 + 32'(lvl * 3), 32'd1 + 32'(lvl), 1'b0);
        sender_no_gaps = 1'b0;
        send_order(32'd1001, 32'd50, 1'b0);
        send_order(32'd999, 32'd50, 1'b0);
        send_order(32'd1000, 32'd50, 1'b0);
        send_order(32'hFFFF_FFFF, 32'd60, 1'b1);
        send_order(32'd1100, 32'd300, 1'b1);
        send_order(32'd1001, 32'd9, 1'b0);
        send_order(32'd0, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Mostly a narrow price band, so orders keep crossing and levels keep
    // opening, joining and emptying. A few orders use full-width prices or
    // amounts, and long back-to-back stretches alternate with idle ones.
    task automatic test_random_flow(input int count);
        int                           n;
        logic [lobm_pkg::PRICE_W-1:0] price;
        logic [lobm_pkg::AMT_W-1:0]   amount;

        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                sender_no_gaps = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 15))
                0:       price = $urandom;
                1:       price = 32'hFFFF_FFFF - $urandom_range(0, 3);
                2:       price = $urandom_range(0, 3);
                default: price = 32'd5000 + $urandom_range(0, 50);
            endcase
            case ($urandom_range(0, 15))
                0:       amount = $urandom;
                1:       amount = 32'd0;
                2:       amount = 32'hFFFF_FFFF;
                default: amount = $urandom_range(1, 400);
            endcase
            send_order(price, amount, 1'($urandom_range(0, 1)));
        end
        sender_no_gaps = 1'b0;
    endtask

    // Result side: waits a random number of cycles before taking each result,
    // and serves long hold-off requests counted down here.
    initial
    begin
        int stall;

        out_ready     = 1'b0;
        receiver_hold = 0;
        stall         = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (receiver_hold > 0)
            begin
                receiver_hold--;
                out_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= (stall == 0);
            end
            else if (out_valid && out_ready)
            begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                out_ready <= (stall == 0);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: a returned result is checked first, then an accepted request
    // is run through the private book. Both are sampled at the rising edge.
    initial
    begin
        fill_report_t want;

        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_fills.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request outstanding", $realtime);
                end
                else
                begin
                    want = pending_fills.pop_front();
                    if (filled_amount !== want.filled || backlog_total !== want.total ||
                        backlog_total_mod !== want.total_mod ||
                        remainder_dropped !== want.dropped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                     $realtime, want.filled, want.total, want.total_mod,
                                     want.dropped, filled_amount, backlog_total,
                                     backlog_total_mod, remainder_dropped);
                    end
                end
            end
            if (rst_n && in_valid && in_ready)
                book_order(limit_price, order_amount, order_side);
        end
    end

    // Watchdog: ends a run that hangs.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("limit_order_book_matcher test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int drain;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        limit_price    = '0;
        order_amount   = '0;
        order_side     = 1'b0;
        sender_no_gaps = 1'b0;
        resting_qty    = '0;
        book_depth[BUY]  = 0;
        book_depth[SELL] = 0;
        for (int k = 0; k < lobm_pkg::LEVELS; k++)
        begin
            book_price[BUY][k]  = '0;
            book_price[SELL][k] = '0;
            book_qty[BUY][k]    = '0;
            book_qty[SELL][k]   = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_amount();
        test_extremes();
        test_full_side();
        test_random_flow(860);
        in_valid <= 1'b0;

        // Let the last results come back, then a margin for stray outputs.
        drain = 0;
        while (pending_fills.size() != 0 && drain < 50000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (120) @(posedge clk);

        if (mismatches == 0 && pending_fills.size() == 0)
            $display("limit_order_book_matcher test passed");
        else
            $display("limit_order_book_matcher test failed");
        $finish;
    end

endmodule
